@@ sv/grid_line_point_generator_defines.svh @@
// Assertion macros for the grid line point generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GRID_LINE_POINT_GENERATOR_DEFINES_SVH
`define GRID_LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GLPG_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GLPG_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ sv/glpg_pkg.sv @@
// Shared types and constants for the grid line point generator.
// No dependencies; imported by glpg_dda and grid_line_point_generator.
package glpg_pkg;

  localparam int COORD_W       = 6;
  localparam int COORD_MAX_DEF = 63;
  // error term holds 0..2n-1 with n up to 63
  localparam int ERR_W         = COORD_W + 1;
  // working width for the error update, signed
  localparam int SUM_W         = ERR_W + 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ERR_W-1:0]   err_t;

  typedef struct packed {
    logic capture;  // input transaction accepted, latch endpoints
    logic load;     // set up spans and start point
    logic step;     // current point taken, advance one step
  } glpg_ctrl_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } glpg_point_t;

endpackage

@@ sv/grid_line_point_generator.sv @@
// Top level: handshake sequencer and output register around the glpg_dda stepper.
// Depends on glpg_pkg, glpg_dda and grid_line_point_generator_defines.svh.
//
//  channel | direction | payload                                 | flow
//  in_     | input     | start_x, start_y, end_x, end_y          | valid / ready
//  out_    | output    | point_x, point_y, last_point            | valid / ready
//
// A line with major-axis span n gives n+1 points, one per cycle while out_ready
// stays high; the single error-term unit in glpg_dda advances once per point.
// An item holds the block through accept, setup, then n+1 point loads.
// in_ready is high only in the idle state; the output register frees the last
// point to wait while the next transaction is accepted.
// rst_n is synchronous; it clears the sequencer and out_valid.
`include "grid_line_point_generator_defines.svh"

module grid_line_point_generator #(
  parameter int COORD_MAX = glpg_pkg::COORD_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  glpg_pkg::coord_t in_start_x,
  input  glpg_pkg::coord_t in_start_y,
  input  glpg_pkg::coord_t in_end_x,
  input  glpg_pkg::coord_t in_end_y,
  output logic             out_valid,
  input  logic             out_ready,
  output glpg_pkg::coord_t out_point_x,
  output glpg_pkg::coord_t out_point_y,
  output logic             out_last_point
);
  import glpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t      state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  glpg_point_t out_r;
  glpg_ctrl_t  ctrl;
  glpg_point_t point;
  logic        take;

  glpg_dda #(
    .COORD_MAX (COORD_MAX)
  ) u_dda (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .point   (point)
  );

  assign in_ready = (state_r == ST_IDLE);
  // load the next point when the output register is empty or being drained
  assign take     = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.capture = in_valid && in_ready;
    ctrl.load    = (state_r == ST_SETUP);
    ctrl.step    = take;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          if (point.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_r <= point;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_r.x;
  assign out_point_y    = out_r.y;
  assign out_last_point = out_r.last;

  `GLPG_ASSERT_NEXT(a_accept_setup, clk, rst_n, in_valid && in_ready, state_r == ST_SETUP, "accept did not start setup")
  `GLPG_ASSERT_NEXT(a_last_idle, clk, rst_n, take && point.last, (state_r == ST_IDLE) && out_valid_r && out_last_point, "last point did not end the line")
  `GLPG_ASSERT_NOW(a_no_overwrite, clk, rst_n, take && out_valid_r, out_ready, "output register overwritten")

endmodule

@@ sv/glpg_dda.sv @@
// Line stepping datapath: endpoint latch, span setup and the shared error-term unit.
// Depends on glpg_pkg and grid_line_point_generator_defines.svh.
`include "grid_line_point_generator_defines.svh"

module glpg_dda #(
  parameter int COORD_MAX = glpg_pkg::COORD_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glpg_pkg::glpg_ctrl_t ctrl,
  input  glpg_pkg::coord_t     start_x,
  input  glpg_pkg::coord_t     start_y,
  input  glpg_pkg::coord_t     end_x,
  input  glpg_pkg::coord_t     end_y,
  output glpg_pkg::glpg_point_t point
);
  import glpg_pkg::*;

  localparam coord_t CMAX = coord_t'(COORD_MAX);

  coord_t sx_r, sy_r, ex_r, ey_r;
  coord_t maj_r, mnr_r, cnt_r;
  err_t   err_r, n2_r, d2_r;
  logic   xmaj_r, dec_maj_r, dec_min_r;
  logic   armed_r;

  coord_t maj_nxt, mnr_nxt, cnt_nxt;
  err_t   err_nxt, n2_nxt, d2_nxt;
  logic   xmaj_nxt, dec_maj_nxt, dec_min_nxt;

  logic [COORD_W:0]   dx, dy;
  coord_t             adx, ady, span;
  logic               x_major;
  logic signed [SUM_W-1:0] sum, n2_s;

  function automatic coord_t sat(input coord_t v);
    sat = (v > CMAX) ? CMAX : v;
  endfunction

  // span setup from the latched endpoints
  always_comb begin
    dx      = {1'b0, ex_r} - {1'b0, sx_r};
    dy      = {1'b0, ey_r} - {1'b0, sy_r};
    adx     = dx[COORD_W] ? coord_t'(-dx) : coord_t'(dx);
    ady     = dy[COORD_W] ? coord_t'(-dy) : coord_t'(dy);
    x_major = ady < adx;
    span    = x_major ? adx : ady;
  end

  always_comb begin
    maj_nxt     = maj_r;
    mnr_nxt     = mnr_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    n2_nxt      = n2_r;
    d2_nxt      = d2_r;
    xmaj_nxt    = xmaj_r;
    dec_maj_nxt = dec_maj_r;
    dec_min_nxt = dec_min_r;
    n2_s        = $signed({2'b00, n2_r});
    sum         = dec_min_r ? $signed({2'b00, err_r}) - $signed({2'b00, d2_r})
                            : $signed({2'b00, err_r}) + $signed({2'b00, d2_r});
    if (ctrl.load) begin
      xmaj_nxt    = x_major;
      maj_nxt     = x_major ? sx_r : sy_r;
      mnr_nxt     = x_major ? sy_r : sx_r;
      dec_maj_nxt = x_major ? dx[COORD_W] : dy[COORD_W];
      dec_min_nxt = x_major ? dy[COORD_W] : dx[COORD_W];
      cnt_nxt     = span;
      // start halfway: rounding half up
      err_nxt     = {1'b0, span};
      n2_nxt      = {span, 1'b0};
      d2_nxt      = x_major ? {ady, 1'b0} : {adx, 1'b0};
    end else if (ctrl.step) begin
      maj_nxt = dec_maj_r ? maj_r - 1'b1 : maj_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
      // one wrap at most, since the minor span never exceeds the major one
      if (!dec_min_r && (sum >= n2_s)) begin
        err_nxt = err_t'(sum - n2_s);
        mnr_nxt = mnr_r + 1'b1;
      end else if (dec_min_r && sum[SUM_W-1]) begin
        err_nxt = err_t'(sum + n2_s);
        mnr_nxt = mnr_r - 1'b1;
      end else begin
        err_nxt = err_t'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (ctrl.load) begin
      armed_r <= 1'b1;
    end
    if (ctrl.capture) begin
      sx_r <= sat(start_x);
      sy_r <= sat(start_y);
      ex_r <= sat(end_x);
      ey_r <= sat(end_y);
    end
    maj_r     <= maj_nxt;
    mnr_r     <= mnr_nxt;
    cnt_r     <= cnt_nxt;
    err_r     <= err_nxt;
    n2_r      <= n2_nxt;
    d2_r      <= d2_nxt;
    xmaj_r    <= xmaj_nxt;
    dec_maj_r <= dec_maj_nxt;
    dec_min_r <= dec_min_nxt;
  end

  assign point.x    = xmaj_r ? maj_r : mnr_r;
  assign point.y    = xmaj_r ? mnr_r : maj_r;
  assign point.last = (cnt_r == '0);

  `GLPG_ASSERT_NOW(a_step_after_load, clk, rst_n, ctrl.step, armed_r, "step before setup")
  `GLPG_ASSERT_NOW(a_err_bound, clk, rst_n, armed_r && !ctrl.load, (n2_r == '0) || (err_r < n2_r), "error term out of range")

endmodule
